// ===== src/xlsd_pkg.sv =====
// package for the xor linked sorted deque: operation codes, state codes
// and default sizes; no dependencies
package xlsd_pkg;

    localparam int POOL_SLOTS_DEF = 16;
    localparam int VALUE_W = 32;
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_SORTED     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_SEARCH     = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_WAIT,
        ST_TAIL_WAIT,
        ST_LINK_END,
        ST_LINK_NEW,
        ST_POP_WAIT,
        ST_POP_FIX,
        ST_WALK_WAIT,
        ST_FIX_NEW,
        ST_FIX_PREV,
        ST_FIX_NEXT,
        ST_FINISH
    } state_t;

endpackage

// ===== src/xor_linked_sorted_deque.sv =====
// top level of the xor linked sorted deque: pool memories, walk sequencer
// and result register; depends on xlsd_pkg
//
//  channel | valid      | stall      | payload
//  in      | in_valid   | in_stall   | operation, value
//  out     | out_valid  | out_stall  | ok, popped_value, found, is_empty, is_full
//
// clear, unused codes, a full pool and an empty list go straight from
// acceptance to the result; a push links the new node at the old end, a pop
// unlinks the end node; a sorted insert links at an end or first walks the list
// node by node, and a search walks it node by node until a hit or the end
// reset clears head, tail and the result valid and marks only slot 0 of the
// slot map used; the pool memories need no clearing
// a new transaction is taken once the previous result has left the output
// register or is being taken in the same cycle
module xor_linked_sorted_deque #(
    parameter int POOL_SLOTS = xlsd_pkg::POOL_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [xlsd_pkg::OP_W-1:0]    operation,
    input  logic signed [xlsd_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic signed [xlsd_pkg::VALUE_W-1:0] popped_value,
    output logic                         found,
    output logic                         is_empty,
    output logic                         is_full
);
    import xlsd_pkg::*;

    localparam int IW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);

    // pool memories
    logic [VALUE_W-1:0] val_mem [POOL_SLOTS];
    logic [IW-1:0]      lnk_mem [POOL_SLOTS];
    logic [IW-1:0]      rd_addr;
    logic               rd_en;
    logic [VALUE_W-1:0] rd_val;
    logic [IW-1:0]      rd_lnk;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      wr_lnk;
    logic               wv_en;
    logic [IW-1:0]      wv_addr;
    logic [VALUE_W-1:0] wv_data;

    // control state
    state_t               state_reg, state_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [POOL_SLOTS-1:0] used_reg, used_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VALUE_W-1:0]   arg_reg, arg_next;
    logic [IW-1:0]        node_reg, node_next;
    logic [IW-1:0]        end_reg, end_next;
    logic                 front_reg, front_next;
    logic [IW-1:0]        before_reg, before_next;
    logic [IW-1:0]        prev_reg, prev_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        after_reg, after_next;
    logic [CW-1:0]        steps_reg, steps_next;
    logic                 hit_reg, hit_next;

    // result register
    logic                 ov_reg, ov_next;
    logic                 ok_reg, ok_next;
    logic [VALUE_W-1:0]   pop_reg, pop_next;
    logic                 fnd_reg, fnd_next;
    logic                 emp_reg, emp_next;
    logic                 ful_reg, ful_next;

    logic                 out_free;
    logic                 take;
    logic [IW-1:0]        free_idx;
    logic                 pool_full;
    logic [IW-1:0]        walk_nxt;
    logic                 search_stop;
    logic signed [VALUE_W-1:0] rd_sval, arg_sval;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign take     = in_valid && !in_stall;
    assign rd_sval  = rd_val;
    assign arg_sval = arg_reg;
    assign pool_full = &used_reg;

    // next node of a walk: prev xor link(cur)
    assign walk_nxt = prev_reg ^ rd_lnk;
    assign search_stop = (rd_sval == arg_sval) || (walk_nxt == '0)
                         || (steps_reg == CW'(POOL_SLOTS - 1));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = POOL_SLOTS - 1; i >= 1; i--)
        begin
            if (!used_reg[i])
                free_idx = IW'(i);
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_val <= val_mem[rd_addr];
            rd_lnk <= lnk_mem[rd_addr];
        end
        if (wr_en)
            lnk_mem[wr_addr] <= wr_lnk;
        if (wv_en)
            val_mem[wv_addr] <= wv_data;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= POOL_SLOTS'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        arg_reg    <= arg_next;
        node_reg   <= node_next;
        end_reg    <= end_next;
        front_reg  <= front_next;
        before_reg <= before_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        after_reg  <= after_next;
        steps_reg  <= steps_next;
        hit_reg    <= hit_next;
        ok_reg     <= ok_next;
        pop_reg    <= pop_next;
        fnd_reg    <= fnd_next;
        emp_reg    <= emp_next;
        ful_reg    <= ful_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (operation) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                            state_next = (pool_full || head_reg == '0) ? ST_FINISH
                                                                         : ST_LINK_END;
                        OP_SORTED:
                            state_next = (pool_full || head_reg == '0) ? ST_FINISH
                                                                         : ST_HEAD_WAIT;
                        OP_POP_FRONT, OP_POP_BACK:
                            state_next = (head_reg == '0) ? ST_FINISH : ST_POP_WAIT;
                        OP_SEARCH:
                            state_next = (head_reg == '0) ? ST_FINISH : ST_WALK_WAIT;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_HEAD_WAIT: state_next = (arg_sval <= rd_sval) ? ST_LINK_END : ST_TAIL_WAIT;
            ST_TAIL_WAIT: state_next = (arg_sval >= rd_sval) ? ST_LINK_END : ST_WALK_WAIT;
            ST_LINK_END:  state_next = ST_LINK_NEW;
            ST_LINK_NEW:  state_next = ST_FINISH;
            ST_POP_WAIT:  state_next = (head_reg == tail_reg) ? ST_FINISH : ST_POP_FIX;
            ST_POP_FIX:   state_next = ST_FINISH;
            ST_WALK_WAIT:
            begin
                if (op_reg == OP_SEARCH)
                    state_next = search_stop ? ST_FINISH : ST_WALK_WAIT;
                else
                    state_next = (arg_sval >= rd_sval) ? ST_WALK_WAIT : ST_FIX_NEW;
            end
            ST_FIX_NEW:   state_next = ST_FIX_PREV;
            ST_FIX_PREV:  state_next = ST_FIX_NEXT;
            ST_FIX_NEXT:  state_next = ST_FINISH;
            ST_FINISH:    state_next = out_free ? ST_IDLE : ST_FINISH;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs of each state
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        used_next   = used_reg;
        op_next     = op_reg;
        arg_next    = arg_reg;
        node_next   = node_reg;
        end_next    = end_reg;
        front_next  = front_reg;
        before_next = before_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        after_next  = after_reg;
        steps_next  = steps_reg;
        hit_next    = hit_reg;
        ov_next     = ov_reg && out_stall;
        ok_next     = ok_reg;
        pop_next    = pop_reg;
        fnd_next    = fnd_reg;
        emp_next    = emp_reg;
        ful_next    = ful_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_lnk      = '0;
        wv_en       = 1'b0;
        wv_addr     = '0;
        wv_data     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    op_next     = operation;
                    arg_next    = value;
                    hit_next    = 1'b0;
                    ok_next     = 1'b0;
                    pop_next    = '0;
                    steps_next  = '0;
                    node_next   = free_idx;
                    before_next = '0;
                    prev_next   = '0;
                    cur_next    = head_reg;
                    end_next    = head_reg;
                    front_next  = 1'b1;
                    unique case (operation) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
                        begin
                            if (!pool_full)
                            begin
                                ok_next = 1'b1;
                                used_next[free_idx] = 1'b1;
                                wv_en   = 1'b1;
                                wv_addr = free_idx;
                                wv_data = value;
                                if (head_reg == '0)
                                begin
                                    // first node of an empty list
                                    wr_en     = 1'b1;
                                    wr_addr   = free_idx;
                                    head_next = free_idx;
                                    tail_next = free_idx;
                                end
                                else if (operation == OP_PUSH_BACK)
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = tail_reg;
                                    end_next   = tail_reg;
                                    front_next = 1'b0;
                                end
                                else
                                begin
                                    // push front and sorted insert read the head
                                    rd_en   = 1'b1;
                                    rd_addr = head_reg;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (head_reg != '0)
                            begin
                                ok_next = 1'b1;
                                rd_en   = 1'b1;
                                if (operation == OP_POP_BACK)
                                begin
                                    rd_addr    = tail_reg;
                                    end_next   = tail_reg;
                                    front_next = 1'b0;
                                end
                                else
                                    rd_addr = head_reg;
                            end
                        end
                        OP_SEARCH:
                        begin
                            ok_next = 1'b1;
                            if (head_reg != '0)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = head_reg;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (head_reg != '0)
                            begin
                                ok_next   = 1'b1;
                                used_next = POOL_SLOTS'(1);
                                head_next = '0;
                                tail_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HEAD_WAIT:
            begin
                // head data ready: go in front, or fetch the tail
                if (arg_sval > rd_sval)
                begin
                    prev_next  = head_reg;
                    cur_next   = rd_lnk;
                    end_next   = tail_reg;
                    front_next = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = tail_reg;
                end
            end
            ST_TAIL_WAIT:
            begin
                // tail data ready: go behind, or start the walk at head's successor
                if (arg_sval < rd_sval)
                begin
                    rd_en   = 1'b1;
                    rd_addr = cur_reg;
                end
            end
            ST_LINK_END:
            begin
                // old end node gains the new node as neighbour
                wr_en   = 1'b1;
                wr_addr = end_reg;
                wr_lnk  = rd_lnk ^ node_reg;
            end
            ST_LINK_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                wr_lnk  = end_reg;
                if (front_reg)
                    head_next = node_reg;
                else
                    tail_next = node_reg;
            end
            ST_POP_WAIT:
            begin
                pop_next = rd_val;
                used_next[end_reg] = 1'b0;
                if (head_reg == tail_reg)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    // fetch the neighbour of the removed end
                    cur_next = rd_lnk;
                    rd_en    = 1'b1;
                    rd_addr  = rd_lnk;
                end
            end
            ST_POP_FIX:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_lnk  = rd_lnk ^ end_reg;
                if (front_reg)
                    head_next = cur_reg;
                else
                    tail_next = cur_reg;
            end
            ST_WALK_WAIT:
            begin
                if (op_reg == OP_SEARCH)
                begin
                    if (rd_sval == arg_sval)
                        hit_next = 1'b1;
                    else if (!search_stop)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = walk_nxt;
                        prev_next  = cur_reg;
                        cur_next   = walk_nxt;
                        steps_next = steps_reg + CW'(1);
                    end
                end
                else if (arg_sval >= rd_sval)
                begin
                    // step past a node not greater than the value
                    before_next = prev_reg;
                    prev_next   = cur_reg;
                    cur_next    = walk_nxt;
                    rd_en       = 1'b1;
                    rd_addr     = walk_nxt;
                end
                else
                    after_next = walk_nxt;
            end
            ST_FIX_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                wr_lnk  = prev_reg ^ cur_reg;
            end
            ST_FIX_PREV:
            begin
                // prev's link: before ^ n
                wr_en   = 1'b1;
                wr_addr = prev_reg;
                wr_lnk  = before_reg ^ node_reg;
            end
            ST_FIX_NEXT:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_lnk  = node_reg ^ after_reg;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    fnd_next = hit_reg;
                    emp_next = (head_reg == '0);
                    ful_next = pool_full;
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = ov_reg;
    assign ok           = ok_reg;
    assign popped_value = pop_reg;
    assign found        = fnd_reg;
    assign is_empty     = emp_reg;
    assign is_full      = ful_reg;

endmodule

// ===== tb/sv/tb_xor_linked_sorted_deque.sv =====
`timescale 1ns / 1ps
// testbench for the xor linked sorted deque: directed and random transactions
// checked against a behavioural list model; depends on xlsd_pkg and the rtl
module tb_xor_linked_sorted_deque;
    import xlsd_pkg::*;

    localparam int SLOTS = POOL_SLOTS_DEF;
    localparam int CAP = SLOTS - 1;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        ok;
        logic [31:0] popped_value;
        logic        found;
        logic        is_empty;
        logic        is_full;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] operation = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic ok;
    logic signed [VALUE_W-1:0] popped_value;
    logic found;
    logic is_empty;
    logic is_full;

    // list contents, head first
    logic signed [31:0] list_q[$];
    deque_result_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit rx_bursty = 1'b1;

    xor_linked_sorted_deque #(.POOL_SLOTS(SLOTS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .popped_value(popped_value), .found(found),
        .is_empty(is_empty), .is_full(is_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model one operation and return its result
    function automatic deque_result_t apply_op(op_t op, logic signed [31:0] v);
        deque_result_t r;
        int pos;
        r = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
            begin
                if (list_q.size() < CAP)
                begin
                    r.ok = 1'b1;
                    if (op == OP_PUSH_FRONT)
                        list_q.push_front(v);
                    else if (op == OP_PUSH_BACK)
                        list_q.push_back(v);
                    else if (list_q.size() == 0 || v <= list_q[0])
                        list_q.push_front(v);
                    else if (v >= list_q[$])
                        list_q.push_back(v);
                    else
                    begin
                        // after the last node of the leading run not greater than v
                        pos = 1;
                        while (pos < list_q.size() && v >= list_q[pos])
                            pos++;
                        list_q.insert(pos, v);
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (list_q.size() != 0)
                begin
                    r.ok = 1'b1;
                    r.popped_value = (op == OP_POP_FRONT) ? list_q.pop_front()
                                                          : list_q.pop_back();
                end
            end
            OP_SEARCH:
            begin
                r.ok = 1'b1;
                foreach (list_q[i])
                    if (list_q[i] == v)
                        r.found = 1'b1;
            end
            OP_CLEAR:
            begin
                if (list_q.size() != 0)
                begin
                    r.ok = 1'b1;
                    list_q.delete();
                end
            end
            default: ;
        endcase
        r.is_empty = (list_q.size() == 0);
        r.is_full = (list_q.size() == CAP);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // send one transaction and log its expected result
    task automatic send_item(op_t op, logic signed [31:0] v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        value <= v;
        // stall is stable by the falling edge; accepted at the next rising edge
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        expected_q.push_back(apply_op(op, v));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // values drawn from a small set so duplicates and hits are common
    function automatic logic signed [31:0] rand_value();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return $signed($urandom_range(0, 12)) - 6;
        else if (p == 6)
            return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    function automatic op_t rand_op();
        int p;
        p = $urandom_range(0, 99);
        if (p < 14) return OP_PUSH_FRONT;
        if (p < 28) return OP_PUSH_BACK;
        if (p < 50) return OP_SORTED;
        if (p < 62) return OP_POP_FRONT;
        if (p < 74) return OP_POP_BACK;
        if (p < 92) return OP_SEARCH;
        if (p < 96) return OP_CLEAR;
        return OP_NONE;
    endfunction

    task automatic test_empty_cases();
        send_item(OP_POP_FRONT, 32'sd5);
        send_item(OP_POP_BACK, -32'sd1);
        send_item(OP_CLEAR, 32'sd0);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_NONE, -32'sd1);
    endtask

    task automatic test_extremes_and_fill();
        send_item(OP_SORTED, 32'sd10);
        send_item(OP_SORTED, 32'sd10);
        send_item(OP_SORTED, 32'sh80000000);
        send_item(OP_SORTED, 32'sh7fffffff);
        send_item(OP_SORTED, 32'sd3);
        send_item(OP_PUSH_FRONT, 32'sd20);
        send_item(OP_SORTED, 32'sd15);
        send_item(OP_SEARCH, 32'sh7fffffff);
        send_item(OP_SEARCH, 32'sd4);
        while (list_q.size() < CAP)
            send_item(OP_PUSH_BACK, $urandom);
        send_item(OP_SORTED, -32'sd1);
        send_item(OP_NONE, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_CLEAR, 32'sd0);
        send_item(OP_PUSH_BACK, 32'sd7);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_PUSH_FRONT, -32'sd7);
        send_item(OP_POP_BACK, 32'sd0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_item(rand_op(), rand_value());
            if (i == count / 2)
            begin
                // hold off until the block has caught up
                wait_drained();
                rx_bursty = 1'b0;
            end
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (ok !== e.ok)
                begin
                    $error("ok: expected %0d actual %0d", e.ok, ok);
                    errors++;
                end
                if (popped_value !== e.popped_value)
                begin
                    $error("popped_value: expected %0d actual %0d",
                           $signed(e.popped_value), popped_value);
                    errors++;
                end
                if (found !== e.found)
                begin
                    $error("found: expected %0d actual %0d", e.found, found);
                    errors++;
                end
                if (is_empty !== e.is_empty)
                begin
                    $error("is_empty: expected %0d actual %0d", e.is_empty, is_empty);
                    errors++;
                end
                if (is_full !== e.is_full)
                begin
                    $error("is_full: expected %0d actual %0d", e.is_full, is_full);
                    errors++;
                end
            end
        end
        if (rx_bursty && $urandom_range(0, 99) < 8)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < (rx_bursty ? 50 : 25))
            out_stall <= 1'b0;
        else if (!rx_bursty)
            out_stall <= ($urandom_range(0, 99) < 20);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** xor_linked_sorted_deque: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_cases();
        test_extremes_and_fill();
        test_random(1500);
        wait_drained();
        repeat (2 * SLOTS + 10) @(posedge clk);
        if (errors == 0)
            $display("** xor_linked_sorted_deque: PASSED **");
        else
            $display("** xor_linked_sorted_deque: FAILED **");
        $finish;
    end
endmodule
